@@ src/msag_pkg.sv @@
// Shared types and constants of the motor speed loop with adaptive gain.
`default_nettype none
package msag_pkg;

  // Numerator of the speed conversion: 1e6 microseconds per second in Q.8.
  localparam int NumWidth = 28;
  localparam logic [NumWidth-1:0] SPEED_NUM = 28'd256000000;

  localparam int PeriodWidth = 32;
  localparam int SpeedWidth  = 24;
  localparam int ErrWidth    = 25;
  localparam int GainWidth   = 24;
  localparam int MulAWidth   = 25;
  localparam int ProdWidth   = MulAWidth + GainWidth;
  localparam int DmagWidth   = 50;
  localparam int DutyWidth   = 32;
  localparam int CountWidth  = 5;

  localparam logic [SpeedWidth-1:0] SPEED_MAX   = 24'hFF_FFFF;
  localparam logic [GainWidth-1:0]  GAIN_ONE    = 24'd65536;
  localparam logic [DmagWidth-1:0]  DUTY_MAX_MAG = 50'd65536;
  localparam logic [DmagWidth-1:0]  DUTY_MIN_MAG = 50'd2147483648;
  localparam logic [DutyWidth-1:0]  DUTY_MAX    = 32'd65536;
  localparam logic [DutyWidth-1:0]  DUTY_MIN    = 32'h8000_0000;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_TARGET_FREQ     = 3'd0;
  localparam logic [2:0] REG_P_GAIN          = 3'd1;
  localparam logic [2:0] REG_I_STEP          = 3'd2;
  localparam logic [2:0] REG_ENABLE_RUN      = 3'd3;
  localparam logic [2:0] REG_ENABLE_P        = 3'd4;
  localparam logic [2:0] REG_ENABLE_INTEGRAL = 3'd5;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_GAIN = 7'b0000100,
    S_HI   = 7'b0001000,
    S_LO   = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic                done;
    logic [NumWidth-1:0] quotient;
  } div_res_t;

endpackage
`default_nettype wire

@@ src/msag_div.sv @@
// Bit-serial restoring divider for the speed conversion, one quotient bit per cycle.
`default_nettype none
module msag_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [msag_pkg::PeriodWidth-1:0]  divisor,
  output msag_pkg::div_res_t                     res
);

  logic                              busy;
  logic                              done;
  logic                              last_step;
  logic [msag_pkg::CountWidth-1:0]   count;
  logic [msag_pkg::PeriodWidth-1:0]  rem;
  logic [msag_pkg::PeriodWidth-1:0]  dvsr;
  logic [msag_pkg::NumWidth-1:0]     quo;
  logic [msag_pkg::PeriodWidth:0]    shifted;
  logic [msag_pkg::PeriodWidth-1:0]  diff;
  logic                              ge;

  assign shifted   = {rem, quo[msag_pkg::NumWidth-1]};
  assign diff      = shifted[msag_pkg::PeriodWidth-1:0] - dvsr;
  assign ge        = shifted >= {1'b0, dvsr};
  assign last_step = busy && count == msag_pkg::CountWidth'(msag_pkg::NumWidth - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && last_step;
      if (start) begin
        busy <= 1'b1;
      end else if (last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr  <= divisor;
      rem   <= '0;
      quo   <= msag_pkg::SPEED_NUM;
      count <= '0;
    end else if (busy) begin
      rem   <= ge ? diff : shifted[msag_pkg::PeriodWidth-1:0];
      quo   <= {quo[msag_pkg::NumWidth-2:0], ge};
      count <= count + 1'b1;
    end
  end

  assign res.done     = done;
  assign res.quotient = quo;

endmodule
`default_nettype wire

@@ src/msag_mul.sv @@
// Shared multiplier with a registered product, used for the gain and both scale partial products.
`default_nettype none
module msag_mul (
  input  wire logic                              clk,
  input  wire logic [msag_pkg::MulAWidth-1:0]    a,
  input  wire logic [msag_pkg::GainWidth-1:0]    b,
  output logic      [msag_pkg::ProdWidth-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= msag_pkg::ProdWidth'(a) * msag_pkg::ProdWidth'(b);
  end

endmodule
`default_nettype wire

@@ src/motor_speed_adaptive_gain_loop.sv @@
// A period passes through the 28-step serial divide, the gain product, the high and low
// scale products of the shared multiplier (used up to three times), their sum and the
// output step; the low product and the sum are skipped with the integral off. A new period
// is taken only once the last result is stored; with enable_run at 0 it is taken and dropped.
// Reset (rst, synchronous, active high) restores the register defaults, sets the
// integral scale to 1.0 and the previous error to zero, and empties the output.
`default_nettype none
module motor_speed_adaptive_gain_loop (
  input  wire logic         clk,
  input  wire logic         rst,
  // Period input channel.
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [31:0]  period_us,
  // Result channel.
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic signed [31:0] duty,
  output logic [23:0]       measured_freq,
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers.
  logic [23:0] target_freq;
  logic [23:0] p_gain;
  logic [23:0] i_step;
  logic        enable_run;
  logic        enable_p;
  logic        enable_integral;

  // Loop state carried from one transaction to the next.
  logic [23:0]                      integral_scale;
  logic signed [msag_pkg::ErrWidth-1:0] previous_error;

  // Sequencer and working registers.
  msag_pkg::state_t                 state;
  logic [msag_pkg::SpeedWidth-1:0]  speed;
  logic signed [msag_pkg::ErrWidth-1:0] err;
  logic [23:0]                      mag;
  logic [msag_pkg::DmagWidth-1:0]   dmag;

  logic                             in_accept;
  logic                             div_start;
  msag_pkg::div_res_t               div_res;
  logic [msag_pkg::SpeedWidth-1:0]  speed_sat;
  logic [msag_pkg::MulAWidth-1:0]   mul_a;
  logic [msag_pkg::GainWidth-1:0]   mul_b;
  logic [msag_pkg::ProdWidth-1:0]   mul_p;
  logic [msag_pkg::ErrWidth-1:0]    err_abs;
  logic                             out_free;
  logic [msag_pkg::DutyWidth-1:0]   duty_val;
  logic [24:0]                      scale_sum;
  logic                             same_sign;
  logic                             cfg_write;
  logic [2:0]                       cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[4:2];

  // The block takes a transaction only while the sequencer is idle.
  assign in_stall  = (state != msag_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign div_start = in_accept && enable_run;

  // The output register can be written when it is empty or being emptied now.
  assign out_free  = !out_valid || !out_stall;

  msag_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (period_us),
    .res     (div_res)
  );

  // A zero period divides to all ones and so saturates like any short period.
  assign speed_sat = (div_res.quotient[msag_pkg::NumWidth-1:msag_pkg::SpeedWidth] != '0)
                     ? msag_pkg::SPEED_MAX
                     : div_res.quotient[msag_pkg::SpeedWidth-1:0];

  assign err_abs = err[msag_pkg::ErrWidth-1] ? (~err + 1'b1) : err;

  // Operand selection for the shared multiplier. The scale product is split into a high
  // and a low partial product of the 49-bit magnitude so each fits one multiply.
  always_comb begin
    mul_a = err_abs;
    mul_b = enable_p ? p_gain : msag_pkg::GAIN_ONE;
    case (state)
      msag_pkg::S_HI: begin
        mul_a = mul_p[msag_pkg::ProdWidth-1:24];
        mul_b = integral_scale;
      end
      msag_pkg::S_LO: begin
        mul_a = {1'b0, mag};
        mul_b = integral_scale;
      end
      default: begin
        mul_a = err_abs;
        mul_b = enable_p ? p_gain : msag_pkg::GAIN_ONE;
      end
    endcase
  end

  msag_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Clamp: above at 1.0, below at the most negative Q15.16 value.
  always_comb begin
    if (err[msag_pkg::ErrWidth-1]) begin
      duty_val = (dmag > msag_pkg::DUTY_MIN_MAG) ? msag_pkg::DUTY_MIN
                                                 : (~dmag[31:0] + 32'd1);
    end else begin
      duty_val = (dmag > msag_pkg::DUTY_MAX_MAG) ? msag_pkg::DUTY_MAX : dmag[31:0];
    end
  end

  // The scale grows while the error keeps a strict sign and shrinks otherwise.
  assign same_sign = (!previous_error[msag_pkg::ErrWidth-1] && previous_error != '0 &&
                      !err[msag_pkg::ErrWidth-1] && err != '0) ||
                     (previous_error[msag_pkg::ErrWidth-1] && err[msag_pkg::ErrWidth-1]);
  assign scale_sum = {1'b0, integral_scale} + {1'b0, i_step};

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= msag_pkg::S_IDLE;
      out_valid      <= 1'b0;
      integral_scale <= msag_pkg::GAIN_ONE;
      previous_error <= '0;
    end else begin
      if (out_valid && !out_stall && state != msag_pkg::S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        msag_pkg::S_IDLE: begin
          if (div_start) begin
            state <= msag_pkg::S_DIV;
          end
        end
        msag_pkg::S_DIV: begin
          if (div_res.done) begin
            state <= msag_pkg::S_GAIN;
          end
        end
        msag_pkg::S_GAIN: begin
          state <= msag_pkg::S_HI;
        end
        msag_pkg::S_HI: begin
          state <= enable_integral ? msag_pkg::S_LO : msag_pkg::S_OUT;
        end
        msag_pkg::S_LO: begin
          state <= msag_pkg::S_SUM;
        end
        msag_pkg::S_SUM: begin
          state <= msag_pkg::S_OUT;
        end
        msag_pkg::S_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            previous_error <= err;
            if (enable_integral) begin
              if (same_sign) begin
                integral_scale <= scale_sum[24] ? 24'hFF_FFFF : scale_sum[23:0];
              end else if (integral_scale > i_step) begin
                integral_scale <= integral_scale - i_step;
              end else begin
                integral_scale <= '0;
              end
            end
            state <= msag_pkg::S_IDLE;
          end
        end
        default: begin
          state <= msag_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      msag_pkg::S_DIV: begin
        if (div_res.done) begin
          speed <= speed_sat;
          err   <= $signed({1'b0, target_freq}) - $signed({1'b0, speed_sat});
        end
      end
      msag_pkg::S_HI: begin
        mag  <= mul_p[23:0];
        dmag <= msag_pkg::DmagWidth'(mul_p >> 8);
      end
      msag_pkg::S_LO: begin
        dmag <= msag_pkg::DmagWidth'(mul_p);
      end
      msag_pkg::S_SUM: begin
        dmag <= dmag + msag_pkg::DmagWidth'(mul_p >> 24);
      end
      msag_pkg::S_OUT: begin
        if (out_free) begin
          duty          <= duty_val;
          measured_freq <= speed;
        end
      end
      default: begin
        dmag <= dmag;
      end
    endcase
  end

  // Configuration writes; writes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_freq     <= '0;
      p_gain          <= msag_pkg::GAIN_ONE;
      i_step          <= '0;
      enable_run      <= 1'b0;
      enable_p        <= 1'b0;
      enable_integral <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_idx)
        msag_pkg::REG_TARGET_FREQ:     target_freq     <= pwdata[23:0];
        msag_pkg::REG_P_GAIN:          p_gain          <= pwdata[23:0];
        msag_pkg::REG_I_STEP:          i_step          <= pwdata[23:0];
        msag_pkg::REG_ENABLE_RUN:      enable_run      <= pwdata[0];
        msag_pkg::REG_ENABLE_P:        enable_p        <= pwdata[0];
        msag_pkg::REG_ENABLE_INTEGRAL: enable_integral <= pwdata[0];
        default: begin
          enable_run <= enable_run;
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      msag_pkg::REG_TARGET_FREQ:     prdata = {8'd0, target_freq};
      msag_pkg::REG_P_GAIN:          prdata = {8'd0, p_gain};
      msag_pkg::REG_I_STEP:          prdata = {8'd0, i_step};
      msag_pkg::REG_ENABLE_RUN:      prdata = {31'd0, enable_run};
      msag_pkg::REG_ENABLE_P:        prdata = {31'd0, enable_p};
      msag_pkg::REG_ENABLE_INTEGRAL: prdata = {31'd0, enable_integral};
      default:                       prdata = '0;
    endcase
  end

`ifndef SYNTH
  // A new result appears only out of the final sequencer step.
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == msag_pkg::S_OUT))
    else $error("result appeared outside the output step");

  // The divider reports completion only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == msag_pkg::S_DIV))
    else $error("divider finished while the sequencer was not waiting");

  // With the integral off, a delivered result leaves the scale untouched.
  a_scale_hold: assert property (@(posedge clk) disable iff (rst)
    (state == msag_pkg::S_OUT && out_free && !enable_integral) |=> $stable(integral_scale))
    else $error("integral scale changed with the integral disabled");

  // The duty never exceeds 1.0.
  a_duty_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty <= $signed(msag_pkg::DUTY_MAX)))
    else $error("duty above 1.0");
`endif

endmodule
`default_nettype wire

@@ tb/tb_motor_speed_adaptive_gain_loop.sv @@
// Self-checking testbench of the motor speed loop with adaptive integral gain.
module tb_motor_speed_adaptive_gain_loop;

  // Run length and watchdog. The limit leaves a wide margin over the time that the block
  // takes per period plus the random gaps and stalls on both sides.
  localparam int ActiveItems = 1900;
  localparam int CalmItems   = 1700;
  localparam int LimitCycles = 600000;
  // Cycles allowed after the last result before a register write or the end.
  localparam int SettleCycles = 40;
  // Register index 6 is not decoded by the block, so a write to it is dropped.
  localparam logic [2:0] REG_UNUSED = 3'd6;

  typedef struct packed {
    logic signed [31:0] duty;
    logic [23:0]        freq;
  } drive_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [31:0]       period_us;
  logic              out_valid;
  logic              out_stall;
  logic signed [31:0] duty;
  logic [23:0]       measured_freq;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  motor_speed_adaptive_gain_loop dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .period_us     (period_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .duty          (duty),
    .measured_freq (measured_freq),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow copy of the configuration registers, updated at the write edge.
  logic [23:0] target_cfg;
  logic [23:0] gain_cfg;
  logic [23:0] step_cfg;
  logic        run_on;
  logic        p_on;
  logic        i_on;
  // Shadow copy of the loop state.
  logic [23:0] scale_now;
  int          last_err;

  // Predicted drive transactions, oldest first.
  drive_t drive_queue[$];

  int  error_count;
  int  cycle_count;
  int  active_sent;
  bit  idling_on;
  // Trend of the periods around the target: 0 slower, 1 faster, 2 mixed.
  int  trend;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls come in random bursts. The value changes only
  // at the falling edge, so the block sees it settled at the rising edge.
  initial begin : stall_driver
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (idling_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // Predictor of the loop. It is called once per accepted period, in order, so
  // the integral scale and the previous error advance exactly as in the block.
  function automatic void compute_drive(logic [31:0] period);
    logic [31:0] quotient;
    logic [23:0] speed;
    int          err;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] dmag;
    logic [31:0] d;
    logic [24:0] sum;
    drive_t      res;
    if (!run_on) return;
    // A zero period means the rotor is at full speed.
    if (period == 32'd0) begin
      speed = msag_pkg::SPEED_MAX;
    end else begin
      quotient = {4'b0, msag_pkg::SPEED_NUM} / period;
      speed = (quotient > {8'b0, msag_pkg::SPEED_MAX}) ? msag_pkg::SPEED_MAX : quotient[23:0];
    end
    err = int'({8'b0, target_cfg}) - int'({8'b0, speed});
    neg = err < 0;
    mag = neg ? 64'(-err) : 64'(err);
    mag = mag * (p_on ? {40'b0, gain_cfg} : {40'b0, msag_pkg::GAIN_ONE});
    // The Q.24 magnitude is split so that the scale product stays in 64 bits.
    if (i_on) begin
      dmag = (mag >> 24) * {40'b0, scale_now} +
             (((mag & 64'hFF_FFFF) * {40'b0, scale_now}) >> 24);
    end else begin
      dmag = mag >> 8;
    end
    if (neg) begin
      d = (dmag > 64'd2147483648) ? msag_pkg::DUTY_MIN : (~dmag[31:0] + 32'd1);
    end else begin
      d = (dmag > 64'd65536) ? msag_pkg::DUTY_MAX : dmag[31:0];
    end
    // The scale grows only while the error keeps a strict sign.
    if (i_on) begin
      if ((last_err > 0 && err > 0) || (last_err < 0 && err < 0)) begin
        sum = {1'b0, scale_now} + {1'b0, step_cfg};
        scale_now = sum[24] ? 24'hFF_FFFF : sum[23:0];
      end else if (scale_now > step_cfg) begin
        scale_now = scale_now - step_cfg;
      end else begin
        scale_now = 24'd0;
      end
    end
    last_err = err;
    res.duty = d;
    res.freq = speed;
    drive_queue.push_back(res);
  endfunction

  // Result checker. Outputs are sampled at the rising edge, before the block
  // updates them, and every accepted transaction is matched with the oldest
  // prediction.
  always @(posedge clk) begin
    drive_t want;
    if (!rst && out_valid && !out_stall) begin
      if (drive_queue.size() == 0) begin
        $error("unexpected result transaction: duty %0d, measured_freq %0d",
               duty, measured_freq);
        error_count++;
      end else begin
        want = drive_queue.pop_front();
        if (duty !== want.duty) begin
          $error("duty mismatch: expected %0d, actual %0d", want.duty, duty);
          error_count++;
        end
        if (measured_freq !== want.freq) begin
          $error("measured_freq mismatch: expected %0d, actual %0d",
                 want.freq, measured_freq);
          error_count++;
        end
      end
    end
  end

  // Sends one period. A random gap may come first; valid stays high across
  // back-to-back transactions and is only lowered for a gap or when the loop settles.
  task automatic send_period(logic [31:0] period);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    period_us = period;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_drive(period);
    if (run_on) active_sent++;
  endtask

  // Drops valid, then waits until every predicted result has come out and the
  // block has had time to finish any dropped transaction.
  task automatic settle_loop();
    @(negedge clk);
    in_valid = 1'b0;
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One configuration write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    settle_loop();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // Only the low bits of a register are kept; unknown indexes are ignored.
    case (index)
      msag_pkg::REG_TARGET_FREQ:     target_cfg = value[23:0];
      msag_pkg::REG_P_GAIN:          gain_cfg = value[23:0];
      msag_pkg::REG_I_STEP:          step_cfg = value[23:0];
      msag_pkg::REG_ENABLE_RUN:      run_on = value[0];
      msag_pkg::REG_ENABLE_P:        p_on = value[0];
      msag_pkg::REG_ENABLE_INTEGRAL: i_on = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // While the loop is stopped after reset, periods are taken and dropped.
  task automatic test_stopped_loop();
    send_period(32'd1000);
    send_period(32'd0);
  endtask

  // Default gains: speed conversion at zero, short, long and boundary periods.
  task automatic test_speed_conversion();
    write_reg(msag_pkg::REG_ENABLE_RUN, 32'd1);
    send_period(32'd0);
    send_period(32'd1);
    send_period(32'd15);
    send_period(32'd16);
    send_period(32'd255999999);
    send_period(32'd256000001);
    send_period(32'hFFFF_FFFF);
    write_reg(msag_pkg::REG_TARGET_FREQ, 32'd256000);
    send_period(32'd1000);
  endtask

  // Proportional gain at its extremes, with both error signs.
  task automatic test_proportional_gain();
    write_reg(msag_pkg::REG_ENABLE_P, 32'd1);
    write_reg(msag_pkg::REG_P_GAIN, 32'hFF_FFFF);
    send_period(32'd0);
    send_period(32'hFFFF_FFFF);
    write_reg(msag_pkg::REG_TARGET_FREQ, 32'hFF_FFFF);
    send_period(32'd2000);
    write_reg(msag_pkg::REG_P_GAIN, 32'd0);
    send_period(32'd0);
    send_period(32'd7);
  endtask

  // Adaptive scale: growth while the sign holds, saturation, shrinking on a
  // zero error or a sign change, and the floor at zero.
  task automatic test_integral_scale();
    write_reg(msag_pkg::REG_P_GAIN, {8'd0, msag_pkg::GAIN_ONE});
    write_reg(msag_pkg::REG_TARGET_FREQ, 32'd256000);
    write_reg(msag_pkg::REG_I_STEP, 32'hFF_FFFF);
    write_reg(msag_pkg::REG_ENABLE_INTEGRAL, 32'd1);
    send_period(32'd900);
    send_period(32'd800);
    send_period(32'd700);
    send_period(32'd1000);
    send_period(32'd1200);
    send_period(32'd1300);
    write_reg(msag_pkg::REG_I_STEP, 32'd4096);
    send_period(32'd1100);
    send_period(32'd950);
  endtask

  // A write to an undecoded index changes nothing, and oversized values are
  // cut to the register width.
  task automatic test_register_edges();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(msag_pkg::REG_TARGET_FREQ, 32'hAB12_3456);
    write_reg(msag_pkg::REG_ENABLE_P, 32'hFFFF_FFFE);
    send_period(32'd5000);
  endtask

  // Random register setting, the extremes weighted in. The loop is stopped in
  // about one phase in ten.
  task automatic random_setting();
    int pick;
    pick = $urandom_range(0, 4);
    write_reg(msag_pkg::REG_TARGET_FREQ, pick == 0 ? 32'd0 : pick == 1 ? 32'hFF_FFFF :
              pick == 2 ? $urandom : $urandom_range(256 * 10, 256 * 60000));
    pick = $urandom_range(0, 4);
    write_reg(msag_pkg::REG_P_GAIN, pick == 0 ? 32'd0 : pick == 1 ? 32'hFF_FFFF :
              pick == 2 ? {8'd0, msag_pkg::GAIN_ONE} :
              pick == 3 ? $urandom : $urandom_range(0, 1 << 18));
    pick = $urandom_range(0, 4);
    write_reg(msag_pkg::REG_I_STEP, pick == 0 ? 32'd0 : pick == 1 ? 32'hFF_FFFF :
              pick == 2 ? $urandom : $urandom_range(0, 8192));
    write_reg(msag_pkg::REG_ENABLE_RUN, 32'($urandom_range(0, 9) != 0));
    write_reg(msag_pkg::REG_ENABLE_P, $urandom_range(0, 1));
    write_reg(msag_pkg::REG_ENABLE_INTEGRAL, $urandom_range(0, 1));
  endtask

  // Most periods lie near the one that matches the target speed, in runs of
  // one error sign, so the adaptive scale is driven through long climbs and
  // descents. The rest covers the whole field.
  function automatic logic [31:0] random_period();
    int  mode;
    longint base;
    longint jit;
    longint p;
    mode = $urandom_range(0, 9);
    if (mode < 2) return $urandom;
    if (mode == 2) return $urandom_range(0, 300);
    if (mode == 3) return $urandom_range(0, 1 << 20);
    if ($urandom_range(0, 7) == 0) trend = $urandom_range(0, 2);
    base = (target_cfg == 24'd0) ? longint'($urandom_range(1, 1 << 16)) :
           longint'(256000000) / longint'(target_cfg);
    jit = base / 16 + 2;
    case (trend)
      0:       p = base + longint'($urandom_range(1, int'(jit)));
      1:       p = base - longint'($urandom_range(1, int'(jit)));
      default: p = base + longint'($urandom_range(0, int'(2 * jit))) - jit;
    endcase
    if (p < 0) p = 0;
    return p[31:0];
  endfunction

  // Random phases until enough periods have reached the running loop. The
  // final stretch runs with no idling on either side.
  task automatic test_random_loop();
    int count;
    while (active_sent < ActiveItems) begin
      random_setting();
      if (active_sent >= CalmItems) idling_on = 1'b0;
      count = run_on ? $urandom_range(40, 160) : 10;
      repeat (count) send_period(random_period());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    period_us = 32'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 5'd0;
    pwdata = 32'd0;
    error_count = 0;
    cycle_count = 0;
    active_sent = 0;
    idling_on = 1'b1;
    trend = 2;
    // Reset values of the registers and of the loop state.
    target_cfg = 24'd0;
    gain_cfg = msag_pkg::GAIN_ONE;
    step_cfg = 24'd0;
    run_on = 1'b0;
    p_on = 1'b0;
    i_on = 1'b0;
    scale_now = msag_pkg::GAIN_ONE;
    last_err = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_stopped_loop();
    test_speed_conversion();
    test_proportional_gain();
    test_integral_scale();
    test_register_edges();
    test_random_loop();

    settle_loop();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/msag_pkg.sv
src/msag_div.sv
src/msag_mul.sv
src/motor_speed_adaptive_gain_loop.sv
tb/tb_motor_speed_adaptive_gain_loop.sv
